@@ rtl/mrq_pkg.sv @@
// Shared constants, codes and control types of the message ring queue.
package mrq_pkg;

    localparam int CAPACITY       = 16;
    localparam int MAX_ITEM_BYTES = 64;

    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int BYTE_IDX_W = $clog2(MAX_ITEM_BYTES);
    localparam int STORE_AW   = SLOT_W + BYTE_IDX_W;
    localparam int LEN_W      = 7;
    localparam int COUNT_W    = 5;
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [KIND_W-1:0] KIND_PUT_BACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRY_PUT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PUT_FRONT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GET       = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY        = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL_RETRY   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL_DROPPED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_IN_USE   = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_GET
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;      // input transfer in this cycle
        logic copy_run;  // moving the assembled message into its slot
        logic get_run;   // streaming the bytes of a get
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;    // output register can take a result in this cycle
        logic commit;      // offered item completes a message that is stored
        logic get_stream;  // offered item is a get with bytes to deliver
        logic copy_done;   // final byte of the copy is written in this cycle
        logic get_done;    // final byte of the get is read in this cycle
    } dp_status_t;

endpackage

@@ rtl/mrq_stream_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
interface mrq_in_if;
    import mrq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic [LEN_W-1:0]  want_bytes;

    modport source (output valid, kind, data_byte, last, want_bytes, input ready);
    modport sink   (input valid, kind, data_byte, last, want_bytes, output ready);
endinterface

interface mrq_out_if;
    import mrq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last_out;
    logic [LEN_W-1:0]    delivered_length;

    modport source (output valid, status, out_byte, byte_valid, last_out, delivered_length,
                    input ready);
    modport sink   (input valid, status, out_byte, byte_valid, last_out, delivered_length,
                    output ready);
endinterface

@@ rtl/mrq_ctrl.sv @@
// Controller state machine of the message ring queue.
module mrq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mrq_pkg::dp_status_t status,
    output mrq_pkg::cmd_t       cmd
);
    import mrq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign in_ready = (state_reg == ST_IDLE) && status.out_free;
    assign take     = in_ready && in_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && status.commit)
                begin
                    state_next = ST_COPY;
                end
                else if (take && status.get_stream)
                begin
                    state_next = ST_GET;
                end
            end
            ST_COPY:
            begin
                if (status.copy_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_GET:
            begin
                if (status.get_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.take     = take;
        cmd.copy_run = 1'b0;
        cmd.get_run  = 1'b0;
        case (state_reg)
            ST_COPY:  cmd.copy_run = 1'b1;
            ST_GET:   cmd.get_run  = 1'b1;
            default:  cmd.copy_run = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A stored message always leads into the copy into its slot.
    a_commit_copies: assert property (@(posedge clk) disable iff (!rst_n)
        take && status.commit |=> state_reg == ST_COPY)
        else $error("committed put did not start the slot copy");

endmodule

@@ rtl/mrq_datapath.sv @@
// Datapath of the message ring queue: buffers, ring pointers and result register.
module mrq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrq_pkg::cmd_t                 cmd,
    output mrq_pkg::dp_status_t           status,
    input  logic                          cfg_we,
    input  logic [mrq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [mrq_pkg::KIND_W-1:0]    in_kind,
    input  logic [mrq_pkg::BYTE_W-1:0]    in_data_byte,
    input  logic                          in_last,
    input  logic [mrq_pkg::LEN_W-1:0]     in_want_bytes,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mrq_pkg::STATUS_W-1:0]  out_status,
    output logic [mrq_pkg::BYTE_W-1:0]    out_byte,
    output logic                          out_byte_valid,
    output logic                          out_last,
    output logic [mrq_pkg::LEN_W-1:0]     out_length
);
    import mrq_pkg::*;

    // Memories and the slot length table.
    logic [BYTE_W-1:0] store_mem [2**STORE_AW];
    logic [BYTE_W-1:0] asm_mem   [MAX_ITEM_BYTES];
    logic [LEN_W-1:0]  len_regs  [CAPACITY];
    logic [BYTE_W-1:0] store_rd_reg;
    logic [BYTE_W-1:0] asm_rd_reg;

    // Control state.
    logic [LEN_W-1:0]   max_reg;
    logic [COUNT_W-1:0] cap_reg;
    logic [SLOT_W-1:0]  head_reg;
    logic [SLOT_W-1:0]  tail_reg;
    logic [COUNT_W-1:0] held_reg;
    logic [LEN_W-1:0]   asm_len_reg;
    logic               asm_ovf_reg;
    logic [LEN_W-1:0]   copy_cnt_reg;
    logic [LEN_W-1:0]   copy_n_reg;
    logic [SLOT_W-1:0]  copy_slot_reg;
    logic [LEN_W-1:0]   get_idx_reg;
    logic [LEN_W-1:0]   get_n_reg;
    logic [SLOT_W-1:0]  get_slot_reg;
    logic               out_valid_reg;

    // Result payload.
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic                out_bv_reg;
    logic                out_bv_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic [LEN_W-1:0]    out_len_reg;
    logic [LEN_W-1:0]    out_len_next;
    logic                out_load;

    logic [LEN_W-1:0]   eff_max;
    logic [COUNT_W-1:0] eff_cap;
    logic               is_get;
    logic               append_ok;
    logic [LEN_W-1:0]   len_new;
    logic               too_long;
    logic               full;
    logic               held_zero;
    logic [COUNT_W-1:0] head_p1;
    logic [SLOT_W-1:0]  head_inc;
    logic [COUNT_W-1:0] tail_p1;
    logic [SLOT_W-1:0]  tail_inc;
    logic [SLOT_W-1:0]  tail_dec;
    logic [SLOT_W-1:0]  dest_slot;
    logic [LEN_W-1:0]   tail_len;
    logic [LEN_W-1:0]   get_n;
    logic               out_free;
    logic               issue;
    logic [LEN_W-1:0]   get_idx_p1;
    logic [LEN_W-1:0]   copy_cnt_m1;

    always_comb
    begin
        if (max_reg == '0)
            eff_max = LEN_W'(1);
        else if (max_reg > LEN_W'(MAX_ITEM_BYTES))
            eff_max = LEN_W'(MAX_ITEM_BYTES);
        else
            eff_max = max_reg;

        if (cap_reg == '0)
            eff_cap = COUNT_W'(1);
        else if (cap_reg > COUNT_W'(CAPACITY))
            eff_cap = COUNT_W'(CAPACITY);
        else
            eff_cap = cap_reg;
    end

    assign is_get    = (in_kind == KIND_GET);
    assign append_ok = !asm_ovf_reg && (asm_len_reg < eff_max);
    assign len_new   = asm_len_reg + LEN_W'(append_ok);
    assign too_long  = !append_ok || asm_ovf_reg || (len_new > eff_max);
    assign held_zero = (held_reg == '0);
    assign full      = (held_reg >= eff_cap);

    assign head_p1  = COUNT_W'(head_reg) + COUNT_W'(1);
    assign head_inc = (head_p1 >= eff_cap) ? '0 : head_p1[SLOT_W-1:0];
    assign tail_p1  = COUNT_W'(tail_reg) + COUNT_W'(1);
    assign tail_inc = (tail_p1 >= eff_cap) ? '0 : tail_p1[SLOT_W-1:0];
    assign tail_dec = (tail_reg == '0) ? SLOT_W'(eff_cap - COUNT_W'(1))
                                       : tail_reg - SLOT_W'(1);
    assign dest_slot = (in_kind == KIND_PUT_FRONT) ? tail_dec : head_reg;

    always_comb
    begin
        tail_len = len_regs[tail_reg];
        if (tail_len > LEN_W'(MAX_ITEM_BYTES))
            tail_len = LEN_W'(MAX_ITEM_BYTES);
        get_n = (in_want_bytes < tail_len) ? in_want_bytes : tail_len;
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign get_idx_p1  = get_idx_reg + LEN_W'(1);
    assign issue       = cmd.get_run && out_free && (get_idx_reg != get_n_reg);
    assign copy_cnt_m1 = copy_cnt_reg - LEN_W'(1);

    assign status.out_free   = out_free;
    assign status.commit     = !is_get && in_last && !too_long && !full;
    assign status.get_stream = is_get && !held_zero && (get_n != '0);
    assign status.copy_done  = cmd.copy_run && (copy_cnt_reg == copy_n_reg);
    assign status.get_done   = issue && (get_idx_p1 == get_n_reg);

    // Next result: a status-only answer of the accepted item, or one get byte.
    always_comb
    begin
        out_load        = 1'b0;
        out_status_next = STATUS_OK;
        out_bv_next     = 1'b0;
        out_last_next   = 1'b1;
        out_len_next    = '0;
        if (cmd.take && is_get)
        begin
            if (held_zero)
            begin
                out_load        = 1'b1;
                out_status_next = STATUS_EMPTY;
            end
            else if (get_n == '0)
            begin
                out_load = 1'b1;
            end
        end
        else if (cmd.take && in_last)
        begin
            out_load = 1'b1;
            if (too_long)
                out_status_next = STATUS_TOO_LONG;
            else if (full)
                out_status_next = (in_kind == KIND_TRY_PUT) ? STATUS_FULL_DROPPED
                                                            : STATUS_FULL_RETRY;
            else
                out_len_next = len_new;
        end
        else if (issue)
        begin
            out_load      = 1'b1;
            out_bv_next   = 1'b1;
            out_last_next = (get_idx_p1 == get_n_reg);
            out_len_next  = get_n_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= LEN_W'(MAX_ITEM_BYTES);
            cap_reg       <= COUNT_W'(CAPACITY);
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            asm_len_reg   <= '0;
            asm_ovf_reg   <= 1'b0;
            copy_cnt_reg  <= '0;
            copy_n_reg    <= '0;
            get_idx_reg   <= '0;
            get_n_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_MAX_MESSAGE_BYTES))
                max_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_CAPACITY_IN_USE))
                cap_reg <= cfg_data[COUNT_W-1:0];

            if (cmd.take && is_get)
            begin
                if (!held_zero)
                begin
                    tail_reg    <= tail_inc;
                    held_reg    <= held_reg - COUNT_W'(1);
                    get_idx_reg <= '0;
                    get_n_reg   <= get_n;
                end
            end
            else if (cmd.take)
            begin
                if (!in_last)
                begin
                    asm_len_reg <= len_new;
                    asm_ovf_reg <= asm_ovf_reg || !append_ok;
                end
                else
                begin
                    asm_len_reg <= '0;
                    asm_ovf_reg <= 1'b0;
                    if (!too_long && !full)
                    begin
                        if (in_kind == KIND_PUT_FRONT)
                            tail_reg <= tail_dec;
                        else
                            head_reg <= head_inc;
                        held_reg     <= held_reg + COUNT_W'(1);
                        copy_cnt_reg <= '0;
                        copy_n_reg   <= len_new;
                    end
                end
            end

            if (cmd.copy_run)
                copy_cnt_reg <= copy_cnt_reg + LEN_W'(1);
            if (issue)
                get_idx_reg <= get_idx_p1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers and memories.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_bv_reg     <= out_bv_next;
            out_last_reg   <= out_last_next;
            out_len_reg    <= out_len_next;
        end
        if (cmd.take && !is_get && append_ok)
            asm_mem[asm_len_reg[BYTE_IDX_W-1:0]] <= in_data_byte;
        if (cmd.take && !is_get && in_last && !too_long && !full)
        begin
            len_regs[dest_slot] <= len_new;
            copy_slot_reg       <= dest_slot;
        end
        if (cmd.take && is_get)
            get_slot_reg <= tail_reg;
        if (cmd.copy_run)
            asm_rd_reg <= asm_mem[copy_cnt_reg[BYTE_IDX_W-1:0]];
        if (cmd.copy_run && (copy_cnt_reg != '0))
            store_mem[{copy_slot_reg, copy_cnt_m1[BYTE_IDX_W-1:0]}] <= asm_rd_reg;
        if (issue)
            store_rd_reg <= store_mem[{get_slot_reg, get_idx_reg[BYTE_IDX_W-1:0]}];
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_byte       = out_bv_reg ? store_rd_reg : '0;
    assign out_byte_valid = out_bv_reg;
    assign out_last       = out_last_reg;
    assign out_length     = out_len_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= COUNT_W'(CAPACITY))
        else $error("held message count beyond ring capacity");

    a_get_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.get_run |-> get_idx_reg <= get_n_reg)
        else $error("get read index ran past the delivered length");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_run |-> copy_cnt_reg <= copy_n_reg)
        else $error("slot copy ran past the message length");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.copy_run || cmd.get_run) |-> !cmd.take)
        else $error("input transfer while a copy or get is in progress");

endmodule

@@ rtl/message_ring_queue.sv @@
// Top level of the message ring queue: channels, configuration port and wiring.
//
// A ring of 16 message slots, each holding a byte message of up to 64 bytes
// and its length. Put items (kinds 0, 1 and 2) bring one byte each; the bytes
// gather in an assembly buffer and the byte marked last commits the message,
// at the head for a back put or just before the tail for an urgent front put,
// so that the urgent one is read next. A get (kind 3) streams out the oldest
// message one byte per result, truncated to want_bytes; its slot is freed
// when the get is taken. A put byte that is not the last gives no result. The
// last byte of a put gives one status result; when the message is stored, the
// block then copies it from the assembly buffer into its slot through the
// single write port of the message store, and takes no input transfer
// meanwhile. A get that is empty or asks for no bytes gives one result;
// otherwise it takes its input transfer and then delivers one byte per cycle
// from the registered read port of the message store, as fast as the result
// channel takes them. A new input transfer is taken in the same cycle that
// the pending result is taken. Configuration writes land at once and are
// meant for times when no item is in progress; the message store, the slot
// lengths and the assembly buffer start undefined and need no clearing pass.
module message_ring_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    mrq_in_if.sink                         in_ch,
    mrq_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [mrq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mrq_pkg::*;

    // Commands and status between the state machine and the datapath.
    cmd_t       cmd;
    dp_status_t dp_status;

    // The controller owns the input ready and sequences copies and gets.
    mrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (dp_status),
        .cmd      (cmd)
    );

    // The datapath holds all storage and drives the result register, whose
    // valid flag falls only after a transfer on the result channel.
    mrq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (dp_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_kind        (in_ch.kind),
        .in_data_byte   (in_ch.data_byte),
        .in_last        (in_ch.last),
        .in_want_bytes  (in_ch.want_bytes),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_status     (out_ch.status),
        .out_byte       (out_ch.out_byte),
        .out_byte_valid (out_ch.byte_valid),
        .out_last       (out_ch.last_out),
        .out_length     (out_ch.delivered_length)
    );

endmodule
